### rtl/core/cqrs_pkg.sv
// ----------------------------------------------------------------------------
// cqrs_pkg: shared types and constants for the command queue retry sender.
// Holds the ring geometry, item kinds, register indexes and the structs that
// pass between the control logic, the queue memory and the top level.
// ----------------------------------------------------------------------------
package cqrs_pkg;

  // Ring geometry.
  localparam int QUEUE_DEPTH = 5;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

  // Item kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_ENQUEUE = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWERON_DELAY   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEND_INTERVAL   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCOVERY_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_CODE    = 3'd4;

  // Reset values of the registers and state.
  localparam logic [5:0] POWERON_DELAY_RST   = 6'd55;
  localparam logic [3:0] SEND_INTERVAL_RST   = 4'd3;
  localparam logic [2:0] RETRY_LIMIT_RST     = 3'd3;
  localparam logic [3:0] DISCOVERY_LIMIT_RST = 4'd10;
  localparam logic [7:0] CHANNEL_CODE_RST    = 8'h43;
  localparam logic [7:0] CHANNEL_RST         = 8'd1;
  localparam logic [2:0] MISS_MAX            = 3'd7;

  typedef struct packed {
    logic [5:0] poweron_delay;
    logic [3:0] send_interval;
    logic [2:0] retry_limit;
    logic [3:0] discovery_limit;
    logic [7:0] channel_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       reply_seen;
    logic [7:0] cmd_code;
    logic [7:0] cmd_data;
    logic [7:0] reply_max_channel;
    logic [7:0] stored_channel;
  } item_t;

  // Queue memory access for one transaction.
  typedef struct packed {
    logic              wr_en;
    logic [QPTR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [QPTR_W-1:0] rd_addr;
  } mem_req_t;

  // Result flags of the last accepted transaction.
  typedef struct packed {
    logic emit;
    logic send_discovery;
    logic clear_reply;
  } res_flags_t;

  function automatic logic [QPTR_W-1:0] ring_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_LAST) ? '0 : p + QPTR_W'(1);
  endfunction

endpackage

### rtl/core/cqrs_in_if.sv
// ----------------------------------------------------------------------------
// cqrs_in_if: input channel of the command queue retry sender.
// Carries valid, ready and one input item.
// ----------------------------------------------------------------------------
interface cqrs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       reply_seen;
  logic [7:0] cmd_code;
  logic [7:0] cmd_data;
  logic [7:0] reply_max_channel;
  logic [7:0] stored_channel;

  modport source (
    output valid, kind, reply_seen, cmd_code, cmd_data, reply_max_channel,
           stored_channel,
    input  ready
  );
  modport sink (
    input  valid, kind, reply_seen, cmd_code, cmd_data, reply_max_channel,
           stored_channel,
    output ready
  );
endinterface

### rtl/core/cqrs_out_if.sv
// ----------------------------------------------------------------------------
// cqrs_out_if: result channel of the command queue retry sender.
// Carries valid, ready and one result item.
// ----------------------------------------------------------------------------
interface cqrs_out_if;
  logic       valid;
  logic       ready;
  logic       send_command;
  logic [7:0] command_code;
  logic [7:0] command_data;
  logic       send_discovery;
  logic       clear_reply;
  logic [7:0] max_channel;
  logic [7:0] audio_channel;

  modport source (
    output valid, send_command, command_code, command_data, send_discovery,
           clear_reply, max_channel, audio_channel,
    input  ready
  );
  modport sink (
    input  valid, send_command, command_code, command_data, send_discovery,
           clear_reply, max_channel, audio_channel,
    output ready
  );
endinterface

### rtl/core/cqrs_queue_ram.sv
// ----------------------------------------------------------------------------
// cqrs_queue_ram: command ring storage.
// One write port and one registered read port; each entry holds code and data.
// ----------------------------------------------------------------------------
module cqrs_queue_ram (
  input  logic              clk,
  input  cqrs_pkg::mem_req_t req,
  output logic [15:0]       rd_data
);
  import cqrs_pkg::*;

  logic [15:0] mem [QUEUE_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port, registered; data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/core/cqrs_ctrl.sv
// ----------------------------------------------------------------------------
// cqrs_ctrl: pacing, discovery and retry control.
// Updates the sender state on each accepted transaction, issues the ring
// write or read to the queue memory and registers the result flags.
// ----------------------------------------------------------------------------
module cqrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  cqrs_pkg::item_t       item,
  input  cqrs_pkg::cfg_t        cfg,
  output cqrs_pkg::mem_req_t    mem_req,
  output cqrs_pkg::res_flags_t  res,
  output logic [7:0]            max_channel,
  output logic [7:0]            audio_channel
);
  import cqrs_pkg::*;

  logic [5:0]        startup_count, startup_count_next;
  logic [3:0]        interval_count, interval_count_next;
  logic              discovering, discovering_next;
  logic [3:0]        discovery_tries, discovery_tries_next;
  logic [2:0]        miss_count, miss_count_next;
  logic [QPTR_W-1:0] write_pointer, write_pointer_next;
  logic [QPTR_W-1:0] send_pointer, send_pointer_next;
  logic [7:0]        max_channel_reg, max_channel_next;
  logic [7:0]        channel_reg, channel_next;
  logic [7:0]        previous_channel, previous_channel_next;
  res_flags_t        res_next;

  // Next state of one transaction, memory access included.
  always_comb begin
    logic [3:0]        interval_inc;
    logic [3:0]        tries_inc;
    logic [2:0]        miss_inc;
    logic [QPTR_W-1:0] sp_adv;
    logic              decide;

    startup_count_next    = startup_count;
    interval_count_next   = interval_count;
    discovering_next      = discovering;
    discovery_tries_next  = discovery_tries;
    miss_count_next       = miss_count;
    write_pointer_next    = write_pointer;
    send_pointer_next     = send_pointer;
    max_channel_next      = max_channel_reg;
    channel_next          = channel_reg;
    previous_channel_next = previous_channel;
    res_next              = '0;
    mem_req               = '0;
    decide                = 1'b0;
    interval_inc          = interval_count + 4'd1;
    tries_inc             = discovery_tries + 4'd1;
    miss_inc              = (miss_count < MISS_MAX) ? miss_count + 3'd1 : miss_count;
    sp_adv                = ring_next(send_pointer);

    unique case (item.kind)
      KIND_TICK: begin
        if (startup_count < cfg.poweron_delay) begin
          startup_count_next = startup_count + 6'd1;
        end else if (interval_inc >= cfg.send_interval) begin
          interval_count_next = '0;
          decide              = 1'b1;
        end else begin
          interval_count_next = interval_inc;
        end
      end
      KIND_ENQUEUE: begin
        mem_req.wr_en      = 1'b1;
        mem_req.wr_addr    = write_pointer;
        mem_req.wr_data    = {item.cmd_code, item.cmd_data};
        write_pointer_next = ring_next(write_pointer);
      end
      KIND_START: begin
        discovering_next       = 1'b1;
        write_pointer_next     = '0;
        send_pointer_next      = '0;
        res_next.send_discovery = 1'b1;
        res_next.clear_reply    = 1'b1;
      end
      default: begin
      end
    endcase

    // Send decision.
    if (decide) begin
      if (discovering) begin
        if (item.reply_seen) begin
          res_next.clear_reply = 1'b1;
          discovery_tries_next = '0;
          discovering_next     = 1'b0;
          max_channel_next     = item.reply_max_channel;
          if (item.stored_channel <= item.reply_max_channel) begin
            previous_channel_next = channel_reg;
            channel_next          = item.stored_channel;
            mem_req.wr_en         = 1'b1;
            mem_req.wr_addr       = write_pointer;
            mem_req.wr_data       = {cfg.channel_code, item.stored_channel};
            write_pointer_next    = ring_next(write_pointer);
          end
        end else if (tries_inc < cfg.discovery_limit) begin
          discovery_tries_next    = tries_inc;
          res_next.send_discovery = 1'b1;
        end else begin
          discovery_tries_next = '0;
          discovering_next     = 1'b0;
        end
      end else if (item.reply_seen) begin
        miss_count_next      = '0;
        send_pointer_next    = sp_adv;
        res_next.clear_reply = 1'b1;
        if (write_pointer != sp_adv) begin
          res_next.emit   = 1'b1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = sp_adv;
        end
      end else if (write_pointer != send_pointer) begin
        miss_count_next = miss_inc;
        if (miss_inc <= cfg.retry_limit) begin
          res_next.emit   = 1'b1;
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = send_pointer;
        end else begin
          send_pointer_next = sp_adv;
        end
      end else begin
        miss_count_next = '0;
      end
    end

    // Nothing moves without a transaction.
    if (!accept) begin
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      startup_count    <= '0;
      interval_count   <= '0;
      discovering      <= 1'b0;
      discovery_tries  <= '0;
      miss_count       <= '0;
      write_pointer    <= '0;
      send_pointer     <= '0;
      max_channel_reg  <= CHANNEL_RST;
      channel_reg      <= CHANNEL_RST;
      previous_channel <= CHANNEL_RST;
      res              <= '0;
    end else if (accept) begin
      startup_count    <= startup_count_next;
      interval_count   <= interval_count_next;
      discovering      <= discovering_next;
      discovery_tries  <= discovery_tries_next;
      miss_count       <= miss_count_next;
      write_pointer    <= write_pointer_next;
      send_pointer     <= send_pointer_next;
      max_channel_reg  <= max_channel_next;
      channel_reg      <= channel_next;
      previous_channel <= previous_channel_next;
      res              <= res_next;
    end
  end

  assign max_channel   = max_channel_reg;
  assign audio_channel = channel_reg;

  // A transaction never reads and writes the ring at once.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("ring read and write in one transaction");

  // Pointers stay inside the ring.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (write_pointer <= QPTR_LAST) && (send_pointer <= QPTR_LAST))
    else $error("ring pointer out of range");

  // A channel change keeps the old channel.
  a_prev_channel: assert property (@(posedge clk) disable iff (rst)
    accept && (channel_next != channel_reg) |=> previous_channel == $past(channel_reg))
    else $error("previous channel not kept");

  // A command send and a discovery request never share a result.
  a_send_excl: assert property (@(posedge clk) disable iff (rst)
    !(res.emit && res.send_discovery))
    else $error("command and discovery sent together");

  // Without a transaction the ring pointers hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(write_pointer) && $stable(send_pointer))
    else $error("ring pointer moved without a transaction");

endmodule

### rtl/core/command_queue_retry_sender_unit.sv
// ----------------------------------------------------------------------------
// command_queue_retry_sender_unit: tick-paced command sender with retries.
// Keeps a ring of two-byte commands, runs discovery and resends commands
// that see no reply.
//
//   Channel    Role    Carries
//   request    sink    kind, reply_seen, cmd_code, cmd_data, reply_max_channel,
//                      stored_channel
//   response   source  send_command, command_code, command_data,
//                      send_discovery, clear_reply, max_channel, audio_channel
//   cfg_*      write   register index and data, no read-back
//
// In the accept cycle the state is updated and the ring memory read is
// issued; the result is shown from the registered result flags and the
// registered read data of the ring memory. One transaction is in flight at
// a time; a stalled response holds request.ready low. Reset is synchronous;
// the ring memory needs no clearing.
// ----------------------------------------------------------------------------
module command_queue_retry_sender_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  cqrs_in_if.sink                              request,
  cqrs_out_if.source                           response,
  input  logic                                 cfg_we,
  input  logic [cqrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [7:0]                           cfg_wdata
);
  import cqrs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t     state, state_next;
  cfg_t       cfg;
  item_t      item;
  mem_req_t   mem_req;
  res_flags_t res;
  logic [15:0] rd_data;
  logic       accept;
  logic [7:0] max_channel;
  logic [7:0] audio_channel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poweron_delay   <= POWERON_DELAY_RST;
      cfg.send_interval   <= SEND_INTERVAL_RST;
      cfg.retry_limit     <= RETRY_LIMIT_RST;
      cfg.discovery_limit <= DISCOVERY_LIMIT_RST;
      cfg.channel_code    <= CHANNEL_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POWERON_DELAY:   cfg.poweron_delay   <= cfg_wdata[5:0];
        CFG_SEND_INTERVAL:   cfg.send_interval   <= cfg_wdata[3:0];
        CFG_RETRY_LIMIT:     cfg.retry_limit     <= cfg_wdata[2:0];
        CFG_DISCOVERY_LIMIT: cfg.discovery_limit <= cfg_wdata[3:0];
        CFG_CHANNEL_CODE:    cfg.channel_code    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Request gathering.
  assign item.kind              = request.kind;
  assign item.reply_seen        = request.reply_seen;
  assign item.cmd_code          = request.cmd_code;
  assign item.cmd_data          = request.cmd_data;
  assign item.reply_max_channel = request.reply_max_channel;
  assign item.stored_channel    = request.stored_channel;

  assign request.ready = (state == ST_IDLE);
  assign accept        = request.valid && request.ready;

  // Transaction sequencing.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_BUSY;
      ST_BUSY: if (response.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  cqrs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .cfg           (cfg),
    .mem_req       (mem_req),
    .res           (res),
    .max_channel   (max_channel),
    .audio_channel (audio_channel)
  );

  cqrs_queue_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Response drive.
  assign response.valid          = (state == ST_BUSY);
  assign response.send_command   = res.emit;
  assign response.command_code   = res.emit ? rd_data[15:8] : 8'd0;
  assign response.command_data   = res.emit ? rd_data[7:0]  : 8'd0;
  assign response.send_discovery = res.send_discovery;
  assign response.clear_reply    = res.clear_reply;
  assign response.max_channel    = max_channel;
  assign response.audio_channel  = audio_channel;

  // A request is taken only with no response pending.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept |=> response.valid && !request.ready)
    else $error("request taken while response pending");

  // A stalled response keeps its command.
  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    response.valid && !response.ready |=> $stable(response.command_code)
      && $stable(response.command_data))
    else $error("stalled command changed");

  // The sequencer is always in exactly one state.
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("sequencer state not one-hot");

endmodule

### tb/sv/command_queue_retry_sender_unit_tb.sv
// ----------------------------------------------------------------------------
// command_queue_retry_sender_unit_tb: self-checking bench for the sender.
// Runs directed cases for discovery, skipping, endless resends and ignored
// items, then several random traffic phases under different register
// settings and a backpressure run. A shadow of the sender state predicts
// each output transaction, compared field by field with the block's output.
// ----------------------------------------------------------------------------
module command_queue_retry_sender_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cqrs_pkg::*;

  // Kind value that the block accepts and ignores.
  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam logic [15:0] STALL_PATTERN = 16'b1101_0110_0111_1010;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic       send_command;
    logic [7:0] command_code;
    logic [7:0] command_data;
    logic       send_discovery;
    logic       clear_reply;
    logic [7:0] max_channel;
    logic [7:0] audio_channel;
  } sender_output_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_wdata;

  cqrs_in_if  req_if ();
  cqrs_out_if rsp_if ();

  command_queue_retry_sender_unit dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_if),
    .response  (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the sender registers and state.
  cfg_t              cfg_shadow = cfg_t'{POWERON_DELAY_RST, SEND_INTERVAL_RST,
                                         RETRY_LIMIT_RST, DISCOVERY_LIMIT_RST,
                                         CHANNEL_CODE_RST};
  logic [5:0]        startup_ticks = '0;
  logic [3:0]        interval_ticks = '0;
  logic              in_discovery = 1'b0;
  logic [3:0]        discovery_attempts = '0;
  logic [2:0]        silent_decisions = '0;
  logic [7:0]        slot_code [QUEUE_DEPTH];
  logic [7:0]        slot_data [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_slot = '0;
  logic [QPTR_W-1:0] send_slot = '0;
  logic [7:0]        max_chan_q = CHANNEL_RST;
  logic [7:0]        audio_chan_q = CHANNEL_RST;

  sender_output_t outputs_due [$];
  int             mismatch_count = 0;
  int             burst_left = 0;
  bit             gaps_enabled = 1'b1;
  int             hold_request = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin : watchdog
    #5_000_000;
    $display("command_queue_retry_sender_unit_tb: done, errors");
    $finish;
  end

  function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] s);
    return (int'(s) + 1 < QUEUE_DEPTH) ? QPTR_W'(int'(s) + 1) : '0;
  endfunction

  function automatic void store_command(input logic [7:0] code, input logic [7:0] data);
    slot_code[wr_slot] = code;
    slot_data[wr_slot] = data;
    wr_slot = next_slot(wr_slot);
  endfunction

  function automatic void emit_slot(inout sender_output_t o);
    o.send_command = 1'b1;
    o.command_code = slot_code[send_slot];
    o.command_data = slot_data[send_slot];
  endfunction

  // Applies one input transaction to the shadow state and returns the output
  // transaction that the block must produce for it.
  function automatic sender_output_t advance_sender(input item_t it);
    sender_output_t o;
    o = '0;
    case (it.kind)
      KIND_TICK: begin
        if (startup_ticks < cfg_shadow.poweron_delay) begin
          startup_ticks++;
        end else begin
          interval_ticks++;
          if (interval_ticks >= cfg_shadow.send_interval) begin
            interval_ticks = '0;
            if (in_discovery) begin
              // Discovery: take the reply or ask again until the try limit.
              if (it.reply_seen) begin
                o.clear_reply = 1'b1;
                discovery_attempts = '0;
                in_discovery = 1'b0;
                max_chan_q = it.reply_max_channel;
                if (it.stored_channel <= max_chan_q) begin
                  audio_chan_q = it.stored_channel;
                  store_command(cfg_shadow.channel_code, audio_chan_q);
                end
              end else begin
                discovery_attempts++;
                if (discovery_attempts < cfg_shadow.discovery_limit) begin
                  o.send_discovery = 1'b1;
                end else begin
                  discovery_attempts = '0;
                  in_discovery = 1'b0;
                end
              end
            end else if (it.reply_seen) begin
              // A reply advances the ring even when it looks empty.
              silent_decisions = '0;
              send_slot = next_slot(send_slot);
              if (wr_slot != send_slot) emit_slot(o);
              o.clear_reply = 1'b1;
            end else if (wr_slot != send_slot) begin
              // Silence: resend until the miss count passes the retry limit.
              if (silent_decisions != MISS_MAX) silent_decisions++;
              if (silent_decisions <= cfg_shadow.retry_limit) emit_slot(o);
              else send_slot = next_slot(send_slot);
            end else begin
              silent_decisions = '0;
            end
          end
        end
      end
      KIND_ENQUEUE: store_command(it.cmd_code, it.cmd_data);
      KIND_START: begin
        in_discovery = 1'b1;
        wr_slot = '0;
        send_slot = '0;
        o.send_discovery = 1'b1;
        o.clear_reply = 1'b1;
      end
      default: ;
    endcase
    o.max_channel = max_chan_q;
    o.audio_channel = audio_chan_q;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Compares every output transaction with the oldest prediction.
  always @(posedge clk) begin : output_checker
    sender_output_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (outputs_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: output with no prediction", $time);
      end else begin
        want = outputs_due.pop_front();
        check_field("send_command", 8'(want.send_command), 8'(rsp_if.send_command));
        check_field("command_code", want.command_code, rsp_if.command_code);
        check_field("command_data", want.command_data, rsp_if.command_data);
        check_field("send_discovery", 8'(want.send_discovery),
                    8'(rsp_if.send_discovery));
        check_field("clear_reply", 8'(want.clear_reply), 8'(rsp_if.clear_reply));
        check_field("max_channel", want.max_channel, rsp_if.max_channel);
        check_field("audio_channel", want.audio_channel, rsp_if.audio_channel);
      end
    end
  end

  // Output side: changes its stall mode now and then, and holds off for a
  // counted number of cycles when asked to.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       held;
    int       slot;
    mode = RX_ALWAYS;
    mode_left = 0;
    slot = 0;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        held = hold_request;
        hold_request = 0;
        repeat (held) begin
          rsp_if.ready <= 1'b0;
          @(posedge clk);
        end
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_ALWAYS: rsp_if.ready <= 1'b1;
          RX_RANDOM: rsp_if.ready <= ($urandom_range(0, 99) < 65);
          default: begin
            rsp_if.ready <= STALL_PATTERN[slot];
            slot = (slot + 1) % 16;
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one input transaction, in bursts with random gaps between them,
  // and records its prediction once it is accepted.
  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_enabled) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= it.kind;
    req_if.reply_seen <= it.reply_seen;
    req_if.cmd_code <= it.cmd_code;
    req_if.cmd_data <= it.cmd_data;
    req_if.reply_max_channel <= it.reply_max_channel;
    req_if.stored_channel <= it.stored_channel;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    outputs_due.push_back(advance_sender(it));
  endtask

  // Stops offering and waits until every predicted output has been seen.
  task automatic wait_for_outputs();
    req_if.valid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
  endtask

  // Writes all five registers; unused upper data bits carry noise.
  task automatic program_registers(input cfg_t c);
    logic [CFG_INDEX_W-1:0] reg_index [5];
    logic [7:0]             reg_value [5];
    reg_index = '{CFG_POWERON_DELAY, CFG_SEND_INTERVAL, CFG_RETRY_LIMIT,
                  CFG_DISCOVERY_LIMIT, CFG_CHANNEL_CODE};
    reg_value[0] = {2'($urandom), c.poweron_delay};
    reg_value[1] = {4'($urandom), c.send_interval};
    reg_value[2] = {5'($urandom), c.retry_limit};
    reg_value[3] = {4'($urandom), c.discovery_limit};
    reg_value[4] = c.channel_code;
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_wdata <= reg_value[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_shadow = c;
  endtask

  function automatic item_t random_item(input int reply_pct);
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    it.kind = (pick < 60) ? KIND_TICK : (pick < 93) ? KIND_ENQUEUE :
              (pick < 97) ? KIND_START : KIND_IGNORED;
    it.reply_seen = ($urandom_range(0, 99) < reply_pct);
    it.cmd_code = 8'($urandom);
    it.cmd_data = 8'($urandom);
    it.reply_max_channel = 8'($urandom);
    // Half the time the stored channel is drawn within the reported maximum.
    it.stored_channel = $urandom_range(0, 1) ?
                        8'($urandom_range(0, it.reply_max_channel)) : 8'($urandom);
    return it;
  endfunction

  // Writes every ring entry once so that no later send reads an empty slot.
  task automatic test_ring_fill();
    send_item(item_t'{KIND_ENQUEUE, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00});
    send_item(item_t'{KIND_ENQUEUE, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF});
    send_item(item_t'{KIND_ENQUEUE, 1'b0, 8'hAA, 8'h55, 8'h00, 8'h00});
    send_item(item_t'{KIND_ENQUEUE, 1'b0, 8'h55, 8'hAA, 8'h00, 8'h00});
    send_item(item_t'{KIND_ENQUEUE, 1'b0, 8'h01, 8'h80, 8'h00, 8'h00});
  endtask

  // An ignored kind, and a tick swallowed by the power-on delay.
  task automatic test_ignored_and_delay();
    send_item(item_t'{KIND_IGNORED, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_item(item_t'{KIND_TICK, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00});
  endtask

  // Discovery with a reply, a skip at retry limit zero, a discovery that
  // gives up at once, a reply on an empty ring and a stored channel above
  // the reported maximum.
  task automatic test_discovery_paths();
    wait_for_outputs();
    program_registers(cfg_t'{6'd0, 4'd1, 3'd0, 4'd1, 8'hFF});
    send_item(item_t'{KIND_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b1, 8'h00, 8'h00, 8'hFF, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b1, 8'h00, 8'h00, 8'd10, 8'd200});
  endtask

  // Retry limit at its top: the miss count saturates and resends never stop.
  // Also a decision on every tick, a start during discovery and a discovery
  // limit of zero.
  task automatic test_endless_retry();
    wait_for_outputs();
    program_registers(cfg_t'{6'd0, 4'd0, 3'd7, 4'd0, CHANNEL_CODE_RST});
    send_item(item_t'{KIND_ENQUEUE, 1'b0, 8'h12, 8'h34, 8'h00, 8'h00});
    repeat (8) send_item(item_t'{KIND_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_START, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
    send_item(item_t'{KIND_TICK, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00});
  endtask

  // Random traffic in phases, each under its own register setting.
  task automatic test_random_traffic();
    cfg_t phase_cfg;
    int   reply_pct;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: phase_cfg = cfg_t'{6'd63, 4'd15, 3'd6, 4'd15, 8'hFF};
        1: phase_cfg = cfg_t'{6'd0, 4'd1, 3'd0, 4'd1, 8'h00};
        2: phase_cfg = cfg_t'{POWERON_DELAY_RST, SEND_INTERVAL_RST, RETRY_LIMIT_RST,
                              DISCOVERY_LIMIT_RST, CHANNEL_CODE_RST};
        default: phase_cfg = cfg_t'{6'($urandom_range(0, 63)), 4'($urandom_range(1, 15)),
                                    3'($urandom_range(0, 6)), 4'($urandom_range(1, 15)),
                                    8'($urandom)};
      endcase
      reply_pct = $urandom_range(5, 85);
      wait_for_outputs();
      program_registers(phase_cfg);
      gaps_enabled = ($urandom_range(0, 3) != 0);
      repeat (235) send_item(random_item(reply_pct));
    end
  endtask

  // The output side holds off for a long stretch while the input side keeps
  // offering, so the block fills and stalls its input.
  task automatic test_backpressure();
    gaps_enabled = 1'b0;
    hold_request = 150;
    repeat (40) send_item(random_item(50));
    gaps_enabled = 1'b1;
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.kind <= KIND_TICK;
    req_if.reply_seen <= 1'b0;
    req_if.cmd_code <= '0;
    req_if.cmd_data <= '0;
    req_if.reply_max_channel <= '0;
    req_if.stored_channel <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_ring_fill();
    test_ignored_and_delay();
    test_discovery_paths();
    test_endless_retry();
    test_random_traffic();
    test_backpressure();

    // Let the last transaction drain, then keep the clock running for strays.
    wait_for_outputs();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("command_queue_retry_sender_unit_tb: done, clean");
    end else begin
      $display("command_queue_retry_sender_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
